>>> src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg - shared types and constants
// Register map, status codes and the front-to-back queue word.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 13;

    localparam logic [1:0] REG_DEVICE = 2'd0;
    localparam logic [1:0] REG_HALF   = 2'd1;
    localparam logic [1:0] REG_POLL   = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam logic [7:0]  DEVICE_RESET = 8'hA0;
    localparam logic [15:0] HALF_RESET   = 16'd400;
    localparam logic [5:0]  POLL_RESET   = 6'd50;
    localparam logic [15:0] TOP_RESET    = 16'h1FFF;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_NACK  = 2'd2;

    // One tick word as queued between front and back.
    typedef struct packed {
        logic                 start_request;
        logic                 mode;
        logic [ADDR_W-1:0]    start_address;
        logic [COUNT_W-1:0]   byte_count;
        logic                 range_err;
        logic [7:0]           write_byte;
        logic                 write_byte_valid;
        logic                 sda_sample;
    } tick_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic [7:0] read_byte;
        logic       read_byte_valid;
        logic       need_write_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } result_t;

endpackage

>>> src/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front - input stage
// Accepts tick words, range-checks requests and feeds a two-entry queue.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  i2cm_pkg::tick_word_t     in_word,
    input  logic [15:0]              top_address,
    output logic                     q_valid,
    input  logic                     q_ready,
    output i2cm_pkg::tick_word_t     q_word
);
    import i2cm_pkg::*;

    tick_word_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [16:0] sum;
    tick_word_t w;
    logic push, pop;

    // range check: start_address + byte_count against top_address
    always_comb
    begin
        sum = {1'b0, in_word.start_address} + {4'd0, in_word.byte_count};
        w = in_word;
        w.range_err = (sum > {1'b0, top_address});
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> src/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back - bus sequencer
// Runs the I2C bit-timing state machine, one tick word per cycle while words
// arrive and the output side keeps up, into a registered output stage.
// ----------------------------------------------------------------------------
module i2cm_back #(
    parameter int TICK_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  i2cm_pkg::tick_word_t  q_word,
    input  logic [7:0]            device_byte,
    input  logic [15:0]           half_period_ticks,
    input  logic [5:0]            ack_poll_limit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cm_pkg::result_t     out_res
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW,
        PH_ACK_HIGH, PH_WAIT_DATA, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
        PH_MACK_HIGH, PH_RESTART, PH_STOP_A, PH_STOP_B, PH_STOP_C
    } phase_t;

    typedef enum logic [2:0] {
        ST_DEV_W, ST_ADDR_HI, ST_ADDR_LO, ST_DATA, ST_DEV_R
    } stage_t;

    localparam logic [TICK_BITS-1:0] TMAX = {TICK_BITS{1'b1}};

    phase_t              phase_reg, phase_next;
    stage_t              stage_reg, stage_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [2:0]          bit_reg, bit_next;
    logic [7:0]          shift_reg, shift_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [5:0]          poll_reg, poll_next;
    logic                rmode_reg, rmode_next;
    logic [1:0]          stat_reg, stat_next;
    result_t             res_reg, res;
    logic                ovalid_reg;

    logic [TICK_BITS-1:0] half_len;
    logic                 last_tick, step;
    logic [5:0]           poll_inc, lim;
    logic [7:0]           shin;

    // half length: zero acts as one, saturate at the counter range
    always_comb
    begin
        if (TICK_BITS >= 16)
            half_len = TICK_BITS'(half_period_ticks);
        else if (|(half_period_ticks >> TICK_BITS))
            half_len = TMAX;
        else
            half_len = TICK_BITS'(half_period_ticks);
        if (half_len == '0) half_len = TICK_BITS'(1);
    end

    assign last_tick = (tick_reg + TICK_BITS'(1)) >= half_len;
    assign q_ready   = !ovalid_reg || out_ready;
    assign step      = q_valid && q_ready;
    assign lim       = (ack_poll_limit == 6'd0) ? 6'd1 : ack_poll_limit;
    assign poll_inc  = (poll_reg < 6'd63) ? poll_reg + 6'd1 : poll_reg;
    assign shin      = {shift_reg[6:0], q_word.sda_sample};

    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        tick_next  = last_tick ? '0 : tick_reg + TICK_BITS'(1);
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        addr_next  = addr_reg;
        poll_next  = poll_reg;
        rmode_next = rmode_reg;
        stat_next  = stat_reg;
        res        = '0;
        res.busy_res = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                res.scl_level = 1'b1;
                res.busy_res  = 1'b0;
                tick_next     = tick_reg;
                if (q_word.start_request)
                begin
                    if (q_word.range_err)
                    begin
                        stat_next    = STATUS_RANGE;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        stat_next  = STATUS_OK;
                        addr_next  = q_word.start_address;
                        left_next  = q_word.byte_count;
                        rmode_next = q_word.mode;
                        stage_next = ST_DEV_W;
                        phase_next = PH_START_A;
                        tick_next  = '0;
                    end
                end
            end
            PH_START_A:
            begin
                res.scl_level = 1'b1;
                if (last_tick) phase_next = PH_START_B;
            end
            PH_START_B:
            begin
                res.scl_level    = 1'b1;
                res.sda_pull_low = 1'b1;
                if (last_tick)
                begin
                    shift_next = (stage_reg == ST_DEV_R) ? (device_byte | 8'd1)
                                                         : device_byte;
                    bit_next   = 3'd0;
                    phase_next = PH_TX_LOW;
                end
            end
            PH_TX_LOW, PH_TX_HIGH:
            begin
                res.scl_level    = (phase_reg == PH_TX_HIGH);
                res.sda_pull_low = !shift_reg[3'd7 - bit_reg];
                if (last_tick)
                begin
                    if (phase_reg == PH_TX_LOW)
                        phase_next = PH_TX_HIGH;
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7)
                        begin
                            poll_next  = '0;
                            phase_next = PH_ACK_LOW;
                        end
                        else
                            phase_next = PH_TX_LOW;
                    end
                end
            end
            PH_ACK_LOW:
            begin
                if (last_tick) phase_next = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                res.scl_level = 1'b1;
                if (last_tick)
                begin
                    tick_next = tick_reg;
                    if (!q_word.sda_sample)
                    begin
                        poll_next = '0;
                        tick_next = '0;
                        case (stage_reg)
                            ST_DEV_W:
                            begin
                                stage_next = ST_ADDR_HI;
                                shift_next = addr_reg[15:8];
                                bit_next   = 3'd0;
                                phase_next = PH_TX_LOW;
                            end
                            ST_ADDR_HI:
                            begin
                                stage_next = ST_ADDR_LO;
                                shift_next = addr_reg[7:0];
                                bit_next   = 3'd0;
                                phase_next = PH_TX_LOW;
                            end
                            ST_ADDR_LO:
                            begin
                                if (rmode_reg)
                                begin
                                    stage_next = ST_DEV_R;
                                    phase_next = PH_RESTART;
                                end
                                else
                                begin
                                    stage_next = ST_DATA;
                                    phase_next = (left_reg == '0) ? PH_STOP_A
                                                                  : PH_WAIT_DATA;
                                end
                            end
                            ST_DATA:
                                phase_next = (left_reg == '0) ? PH_STOP_A
                                                              : PH_WAIT_DATA;
                            default:
                            begin
                                if (left_reg == '0)
                                    phase_next = PH_STOP_A;
                                else
                                begin
                                    shift_next = '0;
                                    bit_next   = 3'd0;
                                    phase_next = PH_RX_LOW;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        poll_next = poll_inc;
                        if (poll_inc >= lim)
                        begin
                            stat_next  = STATUS_NACK;
                            phase_next = PH_STOP_A;
                            tick_next  = '0;
                        end
                    end
                end
            end
            PH_WAIT_DATA:
            begin
                res.need_write_byte = 1'b1;
                tick_next = tick_reg;
                if (q_word.write_byte_valid)
                begin
                    left_next  = left_reg - COUNT_W'(1);
                    shift_next = q_word.write_byte;
                    bit_next   = 3'd0;
                    tick_next  = '0;
                    phase_next = PH_TX_LOW;
                end
            end
            PH_RX_LOW:
            begin
                if (last_tick) phase_next = PH_RX_HIGH;
            end
            PH_RX_HIGH:
            begin
                res.scl_level = 1'b1;
                if (last_tick)
                begin
                    shift_next = shin;
                    bit_next   = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        res.read_byte       = shin;
                        res.read_byte_valid = 1'b1;
                        left_next  = left_reg - COUNT_W'(1);
                        phase_next = PH_MACK_LOW;
                    end
                    else
                        phase_next = PH_RX_LOW;
                end
            end
            PH_MACK_LOW, PH_MACK_HIGH:
            begin
                res.scl_level    = (phase_reg == PH_MACK_HIGH);
                res.sda_pull_low = (left_reg != '0);
                if (last_tick)
                begin
                    if (phase_reg == PH_MACK_LOW)
                        phase_next = PH_MACK_HIGH;
                    else if (left_reg == '0)
                        phase_next = PH_STOP_A;
                    else
                    begin
                        shift_next = '0;
                        bit_next   = 3'd0;
                        phase_next = PH_RX_LOW;
                    end
                end
            end
            PH_RESTART:
            begin
                if (last_tick) phase_next = PH_START_A;
            end
            PH_STOP_A:
            begin
                res.sda_pull_low = 1'b1;
                if (last_tick) phase_next = PH_STOP_B;
            end
            PH_STOP_B:
            begin
                res.scl_level    = 1'b1;
                res.sda_pull_low = 1'b1;
                if (last_tick) phase_next = PH_STOP_C;
            end
            PH_STOP_C:
            begin
                res.scl_level = 1'b1;
                if (last_tick)
                begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                res.scl_level = 1'b1;
                res.busy_res  = 1'b0;
                phase_next    = PH_IDLE;
                tick_next     = '0;
            end
        endcase
        res.status = stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            stage_reg  <= ST_DEV_W;
            tick_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            addr_reg   <= '0;
            poll_reg   <= '0;
            rmode_reg  <= 1'b0;
            stat_reg   <= STATUS_OK;
            ovalid_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                stage_reg <= stage_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                addr_reg  <= addr_next;
                poll_reg  <= poll_next;
                rmode_reg <= rmode_next;
                stat_reg  <= stat_next;
                res_reg   <= res;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;
endmodule

>>> src/i2c_memory_master.sv
// ----------------------------------------------------------------------------
// i2c_memory_master - I2C master for a two-byte-address serial memory
// Tick-driven bus sequencer with an APB register port.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus timing: the sampled SDA level plus,
// while idle, a read or write request. Every accepted word yields exactly one
// result word carrying SCL, SDA drive and status. A front stage range-checks
// requests and holds up to two words in a queue; the back stage runs the bit
// timing state machine, one word per cycle, into an output register, so the
// sustained rate is one word per clock when the output side keeps up. An
// accepted word passes through the queue and then the output register.
// Registers: 0x0 device byte, 0x4 half period ticks, 0x8 ack poll limit,
// 0xC top address; write only while idle.
module i2c_memory_master #(
    parameter int TICK_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_request,
    input  logic        mode,
    input  logic [15:0] start_address,
    input  logic [12:0] byte_count,
    input  logic [7:0]  write_byte,
    input  logic        write_byte_valid,
    input  logic        sda_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic [7:0]  read_byte,
    output logic        read_byte_valid,
    output logic        need_write_byte,
    output logic        busy_res,
    output logic        done_res,
    output logic [1:0]  status
);
    import i2cm_pkg::*;

    logic [7:0]  device_reg;
    logic [15:0] half_reg;
    logic [5:0]  poll_reg;
    logic [15:0] top_reg;
    tick_word_t  in_word, q_word;
    logic        q_valid, q_ready;
    result_t     res;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_reg <= DEVICE_RESET;
            half_reg   <= HALF_RESET;
            poll_reg   <= POLL_RESET;
            top_reg    <= TOP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_DEVICE: device_reg <= pwdata[7:0];
                REG_HALF:   half_reg   <= pwdata[15:0];
                REG_POLL:   poll_reg   <= pwdata[5:0];
                REG_TOP:    top_reg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEVICE: prdata = {24'd0, device_reg};
            REG_HALF:   prdata = {16'd0, half_reg};
            REG_POLL:   prdata = {26'd0, poll_reg};
            REG_TOP:    prdata = {16'd0, top_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        in_word.start_request    = start_request;
        in_word.mode             = mode;
        in_word.start_address    = start_address;
        in_word.byte_count       = byte_count;
        in_word.range_err        = 1'b0;
        in_word.write_byte       = write_byte;
        in_word.write_byte_valid = write_byte_valid;
        in_word.sda_sample       = sda_sample;
    end

    i2cm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .top_address (top_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_word      (q_word)
    );

    i2cm_back #(.TICK_BITS(TICK_BITS)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_word            (q_word),
        .device_byte       (device_reg),
        .half_period_ticks (half_reg),
        .ack_poll_limit    (poll_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_res           (res)
    );

    assign scl_level       = res.scl_level;
    assign sda_pull_low    = res.sda_pull_low;
    assign read_byte       = res.read_byte;
    assign read_byte_valid = res.read_byte_valid;
    assign need_write_byte = res.need_write_byte;
    assign busy_res        = res.busy_res;
    assign done_res        = res.done_res;
    assign status          = res.status;
endmodule

>>> tb/tb_i2c_memory_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_memory_master - self-checking bench for the I2C memory master
// Drives one tick word per handshake. The stimulus acts as a serial memory:
// it answers acknowledge polls and supplies read data on SDA. An in-bench
// model of the bus sequencer predicts every result word, and a checker
// compares each one field by field. Random stalls appear on both channels.
// ----------------------------------------------------------------------------
module tb_i2c_memory_master;
    import i2cm_pkg::*;

    // Bus sequencer phases, as held at the start of a tick
    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW,
        PH_ACK_HIGH, PH_WAIT_DATA, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
        PH_MACK_HIGH, PH_RESTART, PH_STOP_A, PH_STOP_B, PH_STOP_C
    } bus_phase_t;

    // Which byte is on the bus
    typedef enum logic [2:0] {
        BYTE_DEV_W, BYTE_ADDR_HI, BYTE_ADDR_LO, BYTE_DATA, BYTE_DEV_R
    } byte_stage_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_PRINTS     = 30;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        start_request;
    logic        mode;
    logic [15:0] start_address;
    logic [12:0] byte_count;
    logic [7:0]  write_byte;
    logic        write_byte_valid;
    logic        sda_sample;
    logic        out_valid;
    logic        out_ready;
    logic        scl_level;
    logic        sda_pull_low;
    logic [7:0]  read_byte;
    logic        read_byte_valid;
    logic        need_write_byte;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;

    i2c_memory_master u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_request    (start_request),
        .mode             (mode),
        .start_address    (start_address),
        .byte_count       (byte_count),
        .write_byte       (write_byte),
        .write_byte_valid (write_byte_valid),
        .sda_sample       (sda_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .scl_level        (scl_level),
        .sda_pull_low     (sda_pull_low),
        .read_byte        (read_byte),
        .read_byte_valid  (read_byte_valid),
        .need_write_byte  (need_write_byte),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .status           (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Sequencer model: registers and state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_device;
    logic [15:0] cfg_half;
    logic [5:0]  cfg_polls;
    logic [15:0] cfg_top;

    bus_phase_t  seq_phase;
    byte_stage_t seq_stage;
    logic [16:0] seq_ticks;
    logic [3:0]  seq_bit;
    logic [7:0]  seq_shift;
    logic [12:0] seq_left;
    logic [15:0] seq_addr;
    logic [5:0]  seq_polls;
    logic        seq_read;
    logic [1:0]  seq_status;

    result_t     expected_words[$];

    // Stimulus controls
    bit          gaps_on;
    bit          slave_nacks;
    int          words_sent;
    int          words_checked;
    int          errors;
    int          transfers;
    int          reads_seen;
    int          nacks_seen;
    int          range_seen;

    function automatic logic [16:0] half_ticks();
        return (cfg_half == 16'd0) ? 17'd1 : {1'b0, cfg_half};
    endfunction

    // Counts a tick of the current half; true on its last tick
    function automatic bit half_done();
        if (seq_ticks + 17'd1 >= half_ticks())
        begin
            seq_ticks = '0;
            return 1'b1;
        end
        seq_ticks++;
        return 1'b0;
    endfunction

    function automatic void enter(bus_phase_t p);
        seq_phase = p;
        seq_ticks = '0;
    endfunction

    function automatic void load_byte(logic [7:0] b);
        seq_shift = b;
        seq_bit   = '0;
        enter(PH_TX_LOW);
    endfunction

    function automatic void next_after_ack();
        case (seq_stage)
            BYTE_DEV_W:
            begin
                seq_stage = BYTE_ADDR_HI;
                load_byte(seq_addr[15:8]);
            end
            BYTE_ADDR_HI:
            begin
                seq_stage = BYTE_ADDR_LO;
                load_byte(seq_addr[7:0]);
            end
            BYTE_ADDR_LO:
            begin
                if (seq_read)
                begin
                    seq_stage = BYTE_DEV_R;
                    enter(PH_RESTART);
                end
                else
                begin
                    seq_stage = BYTE_DATA;
                    enter(seq_left == 0 ? PH_STOP_A : PH_WAIT_DATA);
                end
            end
            BYTE_DATA:
                enter(seq_left == 0 ? PH_STOP_A : PH_WAIT_DATA);
            default:
            begin
                if (seq_left == 0)
                    enter(PH_STOP_A);
                else
                begin
                    seq_shift = '0;
                    seq_bit   = '0;
                    enter(PH_RX_LOW);
                end
            end
        endcase
    endfunction

    function automatic void seq_reset();
        cfg_device = DEVICE_RESET;
        cfg_half   = HALF_RESET;
        cfg_polls  = POLL_RESET;
        cfg_top    = TOP_RESET;
        seq_phase  = PH_IDLE;
        seq_stage  = BYTE_DEV_W;
        seq_ticks  = '0;
        seq_bit    = '0;
        seq_shift  = '0;
        seq_left   = '0;
        seq_addr   = '0;
        seq_polls  = '0;
        seq_read   = 1'b0;
        seq_status = STATUS_OK;
    endfunction

    // One tick of the sequencer: returns the result word it produces
    function automatic result_t seq_tick(tick_word_t w);
        result_t r;
        r = '0;
        r.busy_res = 1'b1;
        case (seq_phase)
            PH_IDLE:
            begin
                r.scl_level = 1'b1;
                r.busy_res  = 1'b0;
                if (w.start_request)
                begin
                    if ({1'b0, w.start_address} + 17'(w.byte_count) > {1'b0, cfg_top})
                    begin
                        seq_status = STATUS_RANGE;
                        r.done_res = 1'b1;
                    end
                    else
                    begin
                        seq_status = STATUS_OK;
                        seq_addr   = w.start_address;
                        seq_left   = w.byte_count;
                        seq_read   = w.mode;
                        seq_stage  = BYTE_DEV_W;
                        enter(PH_START_A);
                    end
                end
            end
            PH_START_A:
            begin
                r.scl_level = 1'b1;
                if (half_done())
                    enter(PH_START_B);
            end
            PH_START_B:
            begin
                r.scl_level    = 1'b1;
                r.sda_pull_low = 1'b1;
                if (half_done())
                    load_byte(seq_stage == BYTE_DEV_R ? (cfg_device | 8'h01)
                                                      : cfg_device);
            end
            PH_TX_LOW, PH_TX_HIGH:
            begin
                r.scl_level    = (seq_phase == PH_TX_HIGH);
                r.sda_pull_low = !seq_shift[3'd7 - seq_bit[2:0]];
                if (half_done())
                begin
                    if (seq_phase == PH_TX_LOW)
                        seq_phase = PH_TX_HIGH;
                    else
                    begin
                        seq_bit++;
                        if (seq_bit >= 4'd8)
                        begin
                            seq_bit   = '0;
                            seq_polls = '0;
                            enter(PH_ACK_LOW);
                        end
                        else
                            seq_phase = PH_TX_LOW;
                    end
                end
            end
            PH_ACK_LOW:
                if (half_done())
                    enter(PH_ACK_HIGH);
            PH_ACK_HIGH:
            begin
                r.scl_level = 1'b1;
                if (seq_ticks + 17'd1 < half_ticks())
                    seq_ticks++;
                else if (!w.sda_sample)
                begin
                    seq_polls = '0;
                    next_after_ack();
                end
                else
                begin
                    if (seq_polls < 6'd63)
                        seq_polls++;
                    // a limit of zero acts as one
                    if (seq_polls >= cfg_polls)
                    begin
                        seq_status = STATUS_NACK;
                        enter(PH_STOP_A);
                    end
                end
            end
            PH_WAIT_DATA:
            begin
                r.need_write_byte = 1'b1;
                if (w.write_byte_valid)
                begin
                    seq_left--;
                    load_byte(w.write_byte);
                end
            end
            PH_RX_LOW:
                if (half_done())
                    seq_phase = PH_RX_HIGH;
            PH_RX_HIGH:
            begin
                r.scl_level = 1'b1;
                if (half_done())
                begin
                    seq_shift = {seq_shift[6:0], w.sda_sample};
                    seq_bit++;
                    if (seq_bit >= 4'd8)
                    begin
                        seq_bit           = '0;
                        r.read_byte       = seq_shift;
                        r.read_byte_valid = 1'b1;
                        seq_left--;
                        enter(PH_MACK_LOW);
                    end
                    else
                        seq_phase = PH_RX_LOW;
                end
            end
            PH_MACK_LOW, PH_MACK_HIGH:
            begin
                r.scl_level    = (seq_phase == PH_MACK_HIGH);
                r.sda_pull_low = (seq_left != 0);
                if (half_done())
                begin
                    if (seq_phase == PH_MACK_LOW)
                        seq_phase = PH_MACK_HIGH;
                    else if (seq_left == 0)
                        enter(PH_STOP_A);
                    else
                    begin
                        seq_shift = '0;
                        seq_bit   = '0;
                        enter(PH_RX_LOW);
                    end
                end
            end
            PH_RESTART:
                if (half_done())
                    enter(PH_START_A);
            PH_STOP_A:
            begin
                r.sda_pull_low = 1'b1;
                if (half_done())
                    enter(PH_STOP_B);
            end
            PH_STOP_B:
            begin
                r.scl_level    = 1'b1;
                r.sda_pull_low = 1'b1;
                if (half_done())
                    enter(PH_STOP_C);
            end
            default:
            begin
                r.scl_level = 1'b1;
                if (half_done())
                begin
                    r.done_res = 1'b1;
                    enter(PH_IDLE);
                end
            end
        endcase
        r.status = seq_status;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one tick word per call, with random gaps before it
    // ------------------------------------------------------------------
    task automatic send_word(tick_word_t w);
        result_t r;
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        r = seq_tick(w);
        expected_words.push_back(r);
        if (r.read_byte_valid)
            reads_seen++;
        if (r.done_res && r.status == STATUS_RANGE)
            range_seen++;
        if (r.done_res && r.status == STATUS_NACK)
            nacks_seen++;
        in_valid         <= 1'b1;
        start_request    <= w.start_request;
        mode             <= w.mode;
        start_address    <= w.start_address;
        byte_count       <= w.byte_count;
        write_byte       <= w.write_byte;
        write_byte_valid <= w.write_byte_valid;
        sda_sample       <= w.sda_sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Random word; the memory side answers according to the current phase
    function automatic tick_word_t memory_word();
        tick_word_t w;
        w = tick_word_t'({$urandom, $urandom});
        w.range_err     = 1'b0;
        // stray requests are rare so that they mostly land while busy
        w.start_request = ($urandom_range(0, 15) == 0);
        case (seq_phase)
            PH_ACK_HIGH:  w.sda_sample = slave_nacks ? 1'b1 : ($urandom_range(0, 9) == 0);
            PH_WAIT_DATA: w.write_byte_valid = ($urandom_range(0, 3) != 0);
            default:      ;
        endcase
        if (seq_phase == PH_IDLE)
            w.start_request = 1'b0;
        return w;
    endfunction

    // Issues a request and clocks the bus until the transfer is over
    task automatic run_transfer(logic md, logic [15:0] addr, logic [12:0] cnt);
        tick_word_t w;
        w               = memory_word();
        w.start_request = 1'b1;
        w.mode          = md;
        w.start_address = addr;
        w.byte_count    = cnt;
        send_word(w);
        transfers++;
        while (seq_phase != PH_IDLE)
            send_word(memory_word());
    endtask

    // Short request that fits under the top address, or one that overruns it
    task automatic random_transfer(bit allow_range);
        logic [12:0] cnt;
        logic [16:0] room;
        if (allow_range && $urandom_range(0, 7) == 0)
        begin
            cnt = 13'($urandom);
            run_transfer(1'($urandom), 16'hFFFF, cnt | 13'h1);
            return;
        end
        cnt  = ($urandom_range(0, 5) == 0) ? 13'd0 : 13'($urandom_range(1, 4));
        room = (cfg_top >= cnt) ? 17'(cfg_top - cnt) : 17'd0;
        if (cfg_top < cnt)
            cnt = 13'(cfg_top);
        run_transfer(1'($urandom), 16'($urandom_range(0, 32'(room))), cnt);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEVICE: cfg_device = value[7:0];
            REG_HALF:   cfg_half   = value[15:0];
            REG_POLL:   cfg_polls  = value[5:0];
            default:    cfg_top    = value[15:0];
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker with random back-pressure
    // ------------------------------------------------------------------
    int stall_left;
    int idle_cycles;

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        logic    ready_next;
        if (!rst_n)
        begin
            stall_left  = 0;
            idle_cycles = 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no word moved for %0d cycles",
                         $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                got = '{scl_level, sda_pull_low, read_byte, read_byte_valid,
                        need_write_byte, busy_res, done_res, status};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_PRINTS)
                        $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= MAX_PRINTS)
                        begin
                            $display("%0t: word %0d expected scl %b sda %b rd %h/%b %s",
                                     $time, words_checked,
                                     want.scl_level, want.sda_pull_low, want.read_byte,
                                     want.read_byte_valid, "");
                            $display("    need %b busy %b done %b st %0d",
                                     want.need_write_byte, want.busy_res,
                                     want.done_res, want.status);
                            $display("    got scl %b sda %b rd %h/%b",
                                     got.scl_level, got.sda_pull_low, got.read_byte,
                                     got.read_byte_valid);
                            $display("    need %b busy %b done %b st %0d",
                                     got.need_write_byte, got.busy_res,
                                     got.done_res, got.status);
                        end
                    end
                end
            end
            // back-pressure in bursts, none once gaps are off
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every register, edge values, fast bus for the rest
    task automatic test_registers();
        reg_write(REG_DEVICE, 32'd254);
        reg_write(REG_HALF, 32'd1);
        reg_write(REG_POLL, 32'd63);
        reg_write(REG_TOP, 32'd65535);
    endtask

    // Edge requests: overrun at the field limits, zero length, single bytes,
    // a request while busy, write data offered outside the data wait
    task automatic test_directed();
        tick_word_t w;
        run_transfer(1'b0, 16'hFFFF, 13'h1FFF);
        run_transfer(1'b1, 16'hFFFF, 13'd1);
        run_transfer(1'b0, 16'hFFFF, 13'd0);
        run_transfer(1'b1, 16'h0000, 13'd0);
        run_transfer(1'b0, 16'h0000, 13'd1);
        run_transfer(1'b1, 16'h8001, 13'd2);
        reg_write(REG_DEVICE, 32'd0);
        w = '0;
        w.start_request    = 1'b1;
        w.byte_count       = 13'd1;
        w.write_byte       = 8'hFF;
        w.write_byte_valid = 1'b1;
        send_word(w);
        send_word(w);
        while (seq_phase != PH_IDLE)
            send_word(memory_word());
        transfers++;
    endtask

    // Acknowledge never comes: limit of zero, of one, and the maximum
    task automatic test_nack();
        slave_nacks = 1'b1;
        reg_write(REG_POLL, 32'd0);
        run_transfer(1'b0, 16'h0010, 13'd1);
        reg_write(REG_POLL, 32'd1);
        run_transfer(1'b1, 16'h0020, 13'd1);
        reg_write(REG_POLL, 32'd63);
        run_transfer(1'b1, 16'h0030, 13'd2);
        slave_nacks = 1'b0;
        reg_write(REG_POLL, 32'd3);
    endtask

    // Slowest and zero half periods, tight and loose top address
    task automatic test_timing_extremes();
        reg_write(REG_HALF, 32'd65535);
        reg_write(REG_TOP, 32'd0);
        run_transfer(1'b0, 16'd0, 13'd1);
        run_transfer(1'b1, 16'd1, 13'd0);
        reg_write(REG_HALF, 32'd0);
        run_transfer(1'b1, 16'd0, 13'd0);
        reg_write(REG_TOP, 32'd5);
        run_transfer(1'b1, 16'd2, 13'd3);
        run_transfer(1'b0, 16'd3, 13'd3);
    endtask

    // Random transfers under a few settings; one full drain in the middle
    task automatic test_random(int target);
        int setting;
        setting = 0;
        while (words_sent < target)
        begin
            if (transfers % 6 == 0)
            begin
                reg_write(REG_DEVICE, $urandom_range(0, 254));
                reg_write(REG_HALF, $urandom_range(1, 3));
                reg_write(REG_POLL, $urandom_range(1, 4));
                reg_write(REG_TOP, ($urandom_range(0, 1) != 0) ? 65535
                                                               : $urandom_range(8, 8191));
                setting++;
            end
            if (setting == 2 && transfers % 6 == 3)
                wait_idle();
            random_transfer(1'b1);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        start_request    = 1'b0;
        mode             = 1'b0;
        start_address    = '0;
        byte_count       = '0;
        write_byte       = '0;
        write_byte_valid = 1'b0;
        sda_sample       = 1'b1;
        out_ready        = 1'b0;
        gaps_on          = 1'b1;
        slave_nacks      = 1'b0;
        words_sent       = 0;
        words_checked    = 0;
        errors           = 0;
        transfers        = 0;
        reads_seen       = 0;
        nacks_seen       = 0;
        range_seen       = 0;
        seq_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_registers();
        test_directed();
        test_nack();
        test_timing_extremes();
        test_random(1150);
        gaps_on = 1'b0;
        test_random(1450);

        wait_idle();
        $display("Checked %0d words over %0d transfers: %0d bytes read,",
                 words_checked, transfers, reads_seen);
        $display("%0d range and %0d nack ends", range_seen, nacks_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_memory_master.sv
tb/tb_i2c_memory_master.sv
